// ----- sv/kvce_pkg.sv -----
package kvce_pkg;

  // Storage geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int OCC_W   = IDX_W + 1;

  // Field widths
  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int CAP_W = 7;
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Request codes; the fourth code is a no-op
  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Write control from the sequencer to the entry store
  typedef struct packed {
    logic             key_en;
    logic             value_en;
    logic [IDX_W-1:0] addr;
  } store_wr_t;

  // Fold a ring position back into the slot range
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [OCC_W-1:0] s);
    logic [OCC_W-1:0] r;
    r = (s >= OCC_W'(ENTRIES)) ? (s - OCC_W'(ENTRIES)) : s;
    return r[IDX_W-1:0];
  endfunction

endpackage

// ----- sv/kvce_store.sv -----
module kvce_store (
  input  logic                       clk,
  input  logic [kvce_pkg::IDX_W-1:0] rd_addr,
  output logic [kvce_pkg::KEY_W-1:0] rd_key,
  output logic [kvce_pkg::VAL_W-1:0] rd_value,
  input  kvce_pkg::store_wr_t        wr,
  input  logic [kvce_pkg::KEY_W-1:0] wr_key,
  input  logic [kvce_pkg::VAL_W-1:0] wr_value
);

  logic [kvce_pkg::KEY_W-1:0] key_mem   [kvce_pkg::ENTRIES];
  logic [kvce_pkg::VAL_W-1:0] value_mem [kvce_pkg::ENTRIES];

  // Write key and value at one slot
  always_ff @(posedge clk) begin
    if (wr.key_en) begin
      key_mem[wr.addr] <= wr_key;
    end
    if (wr.value_en) begin
      value_mem[wr.addr] <= wr_value;
    end
  end

  // Read both arrays at the same slot, registered
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule

// ----- sv/kvce_seq.sv -----
module kvce_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 operation,
  input  logic [kvce_pkg::KEY_W-1:0] lookup_key,
  input  logic [kvce_pkg::VAL_W-1:0] store_value,
  input  logic [kvce_pkg::OCC_W-1:0] eff_cap,
  output logic                       busy,
  output logic                       done,
  output logic                       found,
  output logic [kvce_pkg::VAL_W-1:0] read_value,
  output logic [kvce_pkg::IDX_W-1:0] rd_addr,
  input  logic [kvce_pkg::KEY_W-1:0] rd_key,
  input  logic [kvce_pkg::VAL_W-1:0] rd_value,
  output kvce_pkg::store_wr_t        wr,
  output logic [kvce_pkg::KEY_W-1:0] wr_key,
  output logic [kvce_pkg::VAL_W-1:0] wr_value
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                     state, state_next;
  logic [1:0]                 op, op_next;
  logic [kvce_pkg::KEY_W-1:0] key, key_next;
  logic [kvce_pkg::VAL_W-1:0] val, val_next;
  logic [kvce_pkg::IDX_W-1:0] replace_slot, replace_slot_next;
  logic [kvce_pkg::OCC_W-1:0] occupancy, occupancy_next;
  logic [kvce_pkg::OCC_W-1:0] issue, issue_next;
  logic                       cmp_vld, cmp_vld_next;
  logic [kvce_pkg::IDX_W-1:0] cmp_slot, cmp_slot_next;
  logic                       done_next, found_next;
  logic [kvce_pkg::VAL_W-1:0] read_value_next;

  logic                       hit, scan_end, full;
  logic [kvce_pkg::IDX_W-1:0] ins_slot;

  // Ring positions: next scanned slot and the slot a new key lands in
  assign rd_addr  = kvce_pkg::wrap_slot(kvce_pkg::OCC_W'(replace_slot) + issue);
  assign ins_slot = kvce_pkg::wrap_slot(kvce_pkg::OCC_W'(replace_slot) + occupancy);

  // Shared key comparator on the registered store output
  assign hit      = cmp_vld && (rd_key == key);
  assign scan_end = !cmp_vld && (issue == occupancy);
  assign full     = occupancy >= eff_cap;

  assign busy     = (state != S_IDLE);
  assign wr_key   = key;
  assign wr_value = val;

  always_comb begin
    state_next        = state;
    op_next           = op;
    key_next          = key;
    val_next          = val;
    replace_slot_next = replace_slot;
    occupancy_next    = occupancy;
    issue_next        = issue;
    cmp_vld_next      = 1'b0;
    cmp_slot_next     = cmp_slot;
    done_next         = 1'b0;
    found_next        = found;
    read_value_next   = read_value;
    wr                = '0;
    wr.addr           = ins_slot;

    unique case (state)
      S_IDLE: begin
        // Take a request and decode it
        if (start) begin
          op_next  = operation;
          key_next = lookup_key;
          val_next = store_value;
          unique case (operation)
            kvce_pkg::OP_GET, kvce_pkg::OP_PUT: begin
              state_next = S_SCAN;
              issue_next = '0;
            end
            kvce_pkg::OP_CLEAR: begin
              occupancy_next    = '0;
              replace_slot_next = '0;
              done_next         = 1'b1;
              found_next        = 1'b0;
              read_value_next   = '0;
            end
            default: begin
              done_next       = 1'b1;
              found_next      = 1'b0;
              read_value_next = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          // Match: return value on get, overwrite value on put
          state_next      = S_IDLE;
          done_next       = 1'b1;
          found_next      = 1'b1;
          read_value_next = (op == kvce_pkg::OP_GET) ? rd_value : '0;
          if (op == kvce_pkg::OP_PUT) begin
            wr.value_en = 1'b1;
            wr.addr     = cmp_slot;
          end
        end else if (scan_end) begin
          // Miss: a put stores the newest entry, evicting the oldest when full
          state_next      = S_IDLE;
          done_next       = 1'b1;
          found_next      = 1'b0;
          read_value_next = '0;
          if (op == kvce_pkg::OP_PUT) begin
            wr.key_en   = 1'b1;
            wr.value_en = 1'b1;
            if (full) begin
              replace_slot_next = kvce_pkg::wrap_slot(kvce_pkg::OCC_W'(replace_slot) +
                                                      kvce_pkg::OCC_W'(1));
            end else begin
              occupancy_next = occupancy + kvce_pkg::OCC_W'(1);
            end
          end
        end else if (issue != occupancy) begin
          // Advance the scan by one slot
          issue_next    = issue + kvce_pkg::OCC_W'(1);
          cmp_vld_next  = 1'b1;
          cmp_slot_next = rd_addr;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      replace_slot <= '0;
      occupancy    <= '0;
      cmp_vld      <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      replace_slot <= replace_slot_next;
      occupancy    <= occupancy_next;
      cmp_vld      <= cmp_vld_next;
      done         <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    key        <= key_next;
    val        <= val_next;
    issue      <= issue_next;
    cmp_slot   <= cmp_slot_next;
    found      <= found_next;
    read_value <= read_value_next;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= kvce_pkg::OCC_W'(kvce_pkg::ENTRIES))
    else $error("occupancy above entry count");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue <= occupancy))
    else $error("scan ran past occupied slots");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while scanning");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (state == S_SCAN))
    else $error("compare pending outside scan");

  a_put_write: assert property (@(posedge clk) disable iff (rst)
    wr.key_en |-> (wr.value_en && op == kvce_pkg::OP_PUT))
    else $error("key written without put");

endmodule

// ----- sv/key_value_cache_fifo_evict_unit.sv -----
// Channel   Handshake                 Payload
// request   start, busy               operation, lookup_key, store_value
// result    done (one-cycle strobe)   found, read_value
// config    cfg_valid, cfg_ready      capacity_in_use
//
// A get or put scans the occupied slots oldest first, one key compare per cycle
// through the registered store read port; a miss compares every occupied slot,
// a hit ends the scan early, and done rises in the same cycle that busy falls.
// Clear and the unused code keep busy low and strobe done in the next cycle.
// Reset empties the store at once (occupancy and ring head to zero); no
// clearing pass. The receiver cannot stall the result.
module key_value_cache_fifo_evict_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 operation,
  input  logic [kvce_pkg::KEY_W-1:0] lookup_key,
  input  logic [kvce_pkg::VAL_W-1:0] store_value,
  output logic                       done,
  output logic                       found,
  output logic [kvce_pkg::VAL_W-1:0] read_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kvce_pkg::CAP_W-1:0] capacity_in_use
);

  logic [kvce_pkg::CAP_W-1:0] capacity;
  logic [kvce_pkg::CMP_W-1:0] cap_ext;
  logic [kvce_pkg::OCC_W-1:0] eff_cap;
  logic [kvce_pkg::IDX_W-1:0] rd_addr;
  logic [kvce_pkg::KEY_W-1:0] rd_key;
  logic [kvce_pkg::VAL_W-1:0] rd_value;
  kvce_pkg::store_wr_t        wr;
  logic [kvce_pkg::KEY_W-1:0] wr_key;
  logic [kvce_pkg::VAL_W-1:0] wr_value;

  // Hold capacity; take writes while idle
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= kvce_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= capacity_in_use;
    end
  end

  // Clamp capacity to one .. ENTRIES
  assign cap_ext = kvce_pkg::CMP_W'(capacity);

  always_comb begin
    if (capacity == '0) begin
      eff_cap = kvce_pkg::OCC_W'(1);
    end else if (cap_ext > kvce_pkg::CMP_W'(kvce_pkg::ENTRIES)) begin
      eff_cap = kvce_pkg::OCC_W'(kvce_pkg::ENTRIES);
    end else begin
      eff_cap = kvce_pkg::OCC_W'(cap_ext);
    end
  end

  kvce_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .lookup_key  (lookup_key),
    .store_value (store_value),
    .eff_cap     (eff_cap),
    .busy        (busy),
    .done        (done),
    .found       (found),
    .read_value  (read_value),
    .rd_addr     (rd_addr),
    .rd_key      (rd_key),
    .rd_value    (rd_value),
    .wr          (wr),
    .wr_key      (wr_key),
    .wr_value    (wr_value)
  );

  kvce_store u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .wr       (wr),
    .wr_key   (wr_key),
    .wr_value (wr_value)
  );

endmodule

// ----- dv/key_value_cache_fifo_evict_unit_tb.sv -----
module key_value_cache_fifo_evict_unit_tb;
  import kvce_pkg::*;

  localparam int          CLK_PERIOD  = 12;
  localparam int          RUN_LIMIT   = CLK_PERIOD * 1_000_000;
  localparam int          SETTLE_CYC  = ENTRIES + 16;
  localparam int          MAX_GAP     = 12;
  localparam int          PRINT_LIMIT = 40;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [63:0] ALL_ONES    = {64{1'b1}};

  typedef struct {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } cache_req_t;

  typedef struct {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic             found;
    logic [VAL_W-1:0] rd_value;
  } cache_reply_t;

  // Unit ports
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       operation = '0;
  logic [KEY_W-1:0] lookup_key = '0;
  logic [VAL_W-1:0] store_value = '0;
  logic             done;
  logic             found;
  logic [VAL_W-1:0] read_value;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] capacity_in_use = '0;

  // Shadow copy of the cache contents
  logic [KEY_W-1:0] shadow_key [ENTRIES];
  logic [VAL_W-1:0] shadow_val [ENTRIES];
  logic             shadow_valid [ENTRIES];
  logic [IDX_W-1:0] oldest_slot = '0;
  logic [OCC_W-1:0] fill_count = '0;
  logic [CAP_W-1:0] capacity_setting = CAP_RESET;

  cache_req_t       pending_reqs [$];
  cache_reply_t     replies_due [$];
  logic [KEY_W-1:0] key_pool [$];

  int  reqs_outstanding = 0;
  int  cfg_writes = 0;
  int  error_count = 0;
  int  gap_left = 0;
  bit  gaps_enabled = 1'b0;
  bit  req_taken = 1'b0;

  // Coverage tallies for the summary
  int  n_reqs = 0;
  int  n_get_hits = 0;
  int  n_overwrites = 0;
  int  n_evictions = 0;
  int  n_over_cap = 0;
  int  n_clears = 0;
  int  n_unused = 0;
  int  peak_fill = 0;

  key_value_cache_fifo_evict_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .lookup_key      (lookup_key),
    .store_value     (store_value),
    .done            (done),
    .found           (found),
    .read_value      (read_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .capacity_in_use (capacity_in_use)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
      shadow_valid[i] = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Apply one request to the shadow cache and return the reply it must give
  function automatic cache_reply_t cache_reply(input cache_req_t req);
    cache_reply_t rsp;
    int           hit;
    int           limit;
    logic [IDX_W-1:0] slot;
    rsp.op = req.op;
    rsp.key = req.key;
    rsp.found = 1'b0;
    rsp.rd_value = '0;
    hit = -1;
    n_reqs++;
    limit = (capacity_setting == 0) ? 1 :
            (capacity_setting > ENTRIES) ? ENTRIES : int'(capacity_setting);
    if (req.op == OP_GET || req.op == OP_PUT) begin
      for (int i = 0; i < ENTRIES; i++)
        if (hit < 0 && shadow_valid[i] && shadow_key[i] == req.key) hit = i;
    end
    case (req.op)
      OP_GET: begin
        if (hit >= 0) begin
          rsp.found = 1'b1;
          rsp.rd_value = shadow_val[hit];
          n_get_hits++;
        end
      end
      OP_PUT: begin
        if (hit >= 0) begin
          rsp.found = 1'b1;
          shadow_val[hit] = req.val;
          n_overwrites++;
        end else begin
          if (fill_count > limit) n_over_cap++;
          // Drop the oldest entry once the cache is at capacity
          if (fill_count >= limit && fill_count > 0) begin
            shadow_valid[oldest_slot] = 1'b0;
            oldest_slot = oldest_slot + 1'b1;
            fill_count = fill_count - 1'b1;
            n_evictions++;
          end
          slot = oldest_slot + fill_count[IDX_W-1:0];
          shadow_key[slot] = req.key;
          shadow_val[slot] = req.val;
          shadow_valid[slot] = 1'b1;
          fill_count = fill_count + 1'b1;
          if (int'(fill_count) > peak_fill) peak_fill = int'(fill_count);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
        fill_count = '0;
        oldest_slot = '0;
        n_clears++;
      end
      default: n_unused++;
    endcase
    return rsp;
  endfunction

  // Drive requests at the falling edge; hold each until the unit takes it
  always @(negedge clk) begin
    cache_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // hold the request steady
    end else if (gap_left == 0 && pending_reqs.size() != 0) begin
      nxt = pending_reqs.pop_front();
      start <= 1'b1;
      operation <= nxt.op;
      lookup_key <= nxt.key;
      store_value <= nxt.val;
      gap_left = gaps_enabled ? $urandom_range(0, MAX_GAP) : 0;
    end else begin
      if (gap_left != 0) gap_left--;
      start <= 1'b0;
      // scramble the idle payload; the unit must ignore it
      operation <= 2'($urandom_range(0, 3));
      lookup_key <= {$urandom, $urandom};
      store_value <= {$urandom, $urandom};
    end
  end

  // Sample handshakes at the rising edge: config, results, then new requests
  always @(posedge clk) begin
    cache_reply_t want;
    cache_req_t   req;
    req_taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        capacity_setting = capacity_in_use;
        cfg_writes++;
      end
      if (done) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          want = replies_due.pop_front();
          reqs_outstanding--;
          if (found !== want.found)
            report_mismatch($sformatf("op %0d key %h: found %b, want %b",
                                      want.op, want.key, found, want.found));
          if (read_value !== want.rd_value)
            report_mismatch($sformatf("op %0d key %h: read_value %h, want %h",
                                      want.op, want.key, read_value, want.rd_value));
        end
      end
      if (start && !busy) begin
        req_taken = 1'b1;
        req.op = operation;
        req.key = lookup_key;
        req.val = store_value;
        replies_due.push_back(cache_reply(req));
      end
    end
  end

  function automatic void queue_req(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                    input logic [VAL_W-1:0] val);
    cache_req_t req;
    req.op = op;
    req.key = key;
    req.val = val;
    pending_reqs.push_back(req);
    reqs_outstanding++;
  endfunction

  // Mostly gets and puts over the key pool, with near misses, fresh and extreme keys, rare clears and unused codes
  function automatic void queue_random_req();
    int               sel;
    int               kind;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    sel = $urandom_range(0, 199);
    op = (sel < 2) ? OP_CLEAR : (sel < 6) ? OP_UNUSED : (sel < 100) ? OP_GET : OP_PUT;
    kind = $urandom_range(0, 19);
    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (kind == 0) key = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
    else if (kind < 3) key = {$urandom, $urandom};
    else if (kind < 5) key = key ^ (64'd1 << $urandom_range(0, 63));
    val = {$urandom, $urandom};
    sel = $urandom_range(0, 15);
    if (sel == 0) val = '0;
    else if (sel == 1) val = ALL_ONES;
    queue_req(op, key, val);
  endfunction

  task automatic run_phase(input int n_items, input int pool_size, input bit with_gaps);
    gaps_enabled = with_gaps;
    key_pool.delete();
    repeat (pool_size) begin
      if ($urandom_range(0, 7) == 0) key_pool.push_back(64'($urandom_range(0, 15)));
      else key_pool.push_back({$urandom, $urandom});
    end
    repeat (n_items) queue_random_req();
    wait (reqs_outstanding == 0);
  endtask

  // Write the capacity register only while the unit is idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    capacity_in_use <= cap;
    wait (cfg_writes != seen);
    @(negedge clk);
    cfg_valid <= 1'b0;
    capacity_in_use <= '0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty lookup, extreme keys and values, overwrite, unused code, clear
    gaps_enabled = 1'b1;
    queue_req(OP_GET, '0, '0);
    queue_req(OP_PUT, '0, ALL_ONES);
    queue_req(OP_PUT, ALL_ONES, '0);
    queue_req(OP_GET, '0, '0);
    queue_req(OP_GET, ALL_ONES, ALL_ONES);
    queue_req(OP_PUT, '0, 64'h5555_5555_5555_5555);
    queue_req(OP_GET, '0, '0);
    queue_req(OP_GET, 64'd1, '0);
    queue_req(OP_GET, 64'h8000_0000_0000_0000, '0);
    queue_req(OP_UNUSED, '0, ALL_ONES);
    queue_req(OP_GET, '0, ALL_ONES);
    queue_req(OP_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 64'd1);
    queue_req(OP_GET, 64'hAAAA_AAAA_AAAA_AAAA, ALL_ONES);
    queue_req(OP_PUT, 64'hAAAA_AAAA_AAAA_AAAA, ALL_ONES);
    queue_req(OP_GET, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    queue_req(OP_CLEAR, '0, ALL_ONES);
    queue_req(OP_GET, '0, '0);
    queue_req(OP_GET, ALL_ONES, '0);
    queue_req(OP_PUT, '0, 64'h0123_4567_89AB_CDEF);
    queue_req(OP_GET, '0, '0);
    wait (reqs_outstanding == 0);

    // Random phases across capacity settings; the first fills past the top
    run_phase(260, 90, 1'b1);
    write_capacity(CAP_W'(4));     // now far below occupancy
    run_phase(220, 10, 1'b0);
    write_capacity(CAP_W'(0));
    run_phase(180, 4, 1'b1);
    write_capacity(CAP_W'(127));
    run_phase(260, 100, 1'b1);
    write_capacity(CAP_W'(1));
    run_phase(150, 3, 1'b1);
    write_capacity(CAP_W'(64));
    run_phase(240, 70, 1'b0);
    repeat (3) begin
      write_capacity(CAP_W'($urandom_range(4, 64)));
      run_phase(160, $urandom_range(4, 96), 1'b1);
    end
    write_capacity(CAP_W'($urandom_range(0, 127)));
    run_phase(120, $urandom_range(2, 80), 1'b1);

    wait (reqs_outstanding == 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));

    $display("Covered %0d requests: %0d get hits, %0d overwrites, %0d evictions, %0d clears",
             n_reqs, n_get_hits, n_overwrites, n_evictions, n_clears);
    $display("  %0d unused codes, %0d capacity writes, peak fill %0d, %0d inserts over capacity",
             n_unused, cfg_writes, peak_fill, n_over_cap);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d requests outstanding", reqs_outstanding);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
sv/kvce_pkg.sv
sv/kvce_store.sv
sv/kvce_seq.sv
sv/key_value_cache_fifo_evict_unit.sv
dv/key_value_cache_fifo_evict_unit_tb.sv
